### rtl/gld_pkg.sv
// Shared types and constants for the GIF LZW pixel decoder.
package gld_pkg;

	localparam int CODE_BITS  = 12;
	localparam int TBL_DEPTH  = 4096;
	localparam int STK_DEPTH  = 4096;
	localparam int CNT_BITS   = 13;
	localparam int COORD_BITS = 16;

	localparam logic [2:0] ST_PIXEL   = 3'd0;
	localparam logic [2:0] ST_NEED    = 3'd1;
	localparam logic [2:0] ST_END     = 3'd2;
	localparam logic [2:0] ST_CLEAR   = 3'd3;
	localparam logic [2:0] ST_ACCEPT  = 3'd4;
	localparam logic [2:0] ST_REFUSE  = 3'd5;
	localparam logic [2:0] ST_STARTED = 3'd6;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_FEED  = 2'd1;
	localparam logic [1:0] OP_ADV   = 2'd2;

	localparam logic [1:0] CFG_MIN    = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;
	localparam logic [1:0] CFG_ILACE  = 2'd3;

	localparam logic [3:0] ROW_STEP [4] = '{4'd8, 4'd8, 4'd4, 4'd2};

	typedef enum logic [1:0] {K_START, K_FEED, K_ADV, K_BAD} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} q_item_t;

	typedef enum logic [2:0] {S_IDLE, S_POP, S_WALK, S_WAIT, S_FIN} core_state_t;

	typedef struct packed {
		logic [15:0] col;
		logic [16:0] row;
		logic [2:0]  pass;
		logic [7:0]  pix;
		logic [15:0] x;
		logic [15:0] y;
		logic        in_img;
		logic        err;
	} place_t;

endpackage

### rtl/gld_front.sv
// Input side: accept stream transfers, classify the opcode, queue the items.
module gld_front
	import gld_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // data_byte
	input  logic [1:0] s_tuser,   // opcode
	output logic       q_valid,
	output q_item_t    q_item,
	input  logic       q_pop
);

	q_item_t    buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	kind_t      kind;

	always_comb begin
		unique case (s_tuser)
			OP_START: kind = K_START;
			OP_FEED:  kind = K_FEED;
			OP_ADV:   kind = K_ADV;
			default:  kind = K_BAD;
		endcase
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= '{kind: kind, data: s_tdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

### rtl/gld_core.sv
// Execution side: bit packer, code table walk, character stack and placement.
module gld_core
	import gld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        q_valid,
	input  q_item_t     q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic [2:0]  m_tuser
);

	logic [3:0]  min_q;
	logic [15:0] w_q, h_q;
	logic        il_q;

	core_state_t state_q, state_d;
	logic [CNT_BITS-1:0]  sc_q, sc_d, next_q, next_d, base_q, base_d;
	logic [19:0] bb_q, bb_d;
	logic [4:0]  bc_q, bc_d;
	logic [7:0]  sb_q, sb_d;
	logic [3:0]  cw_q, cw_d;
	logic [CODE_BITS-1:0] prev_q, prev_d, p_q, p_d, code_q, code_d;
	logic [7:0]  fc_q, fc_d;
	logic        ac_q, ac_d, fin_q, fin_d, err_q, err_d;
	logic [15:0] col_q, col_d;
	logic [16:0] row_q, row_d;
	logic [2:0]  pass_q, pass_d;

	logic        ov_q;
	logic [2:0]  ost_q, ost_d;
	place_t      opl_q, opl_d;
	logic        out_load;

	logic [19:0] tbl_mem [TBL_DEPTH];
	logic [19:0] tbl_rd;
	logic        tbl_we;
	logic [CODE_BITS-1:0] tbl_wa;
	logic [19:0] tbl_wd;
	logic [7:0]  stk_mem [STK_DEPTH];
	logic [7:0]  stk_rd;
	logic        stk_we;
	logic [CNT_BITS-1:0] stk_wa;
	logic [7:0]  stk_wd;
	logic [CNT_BITS-1:0] sc_m1;

	logic [3:0]  m_eff;
	logic [CNT_BITS-1:0] clear_c;
	logic [19:0] mask;
	logic [CODE_BITS-1:0] code;
	logic        take, is_adv, has_code, is_clr, is_end, p_ge, p_ok;
	place_t      pl_a, pl_b;

	function automatic place_t do_place(input logic [7:0] idx, input logic err,
		input logic [15:0] col, input logic [16:0] row, input logic [2:0] pass,
		input logic [15:0] w, input logic [15:0] h, input logic il);
		place_t r;
		logic [16:0] nc;
		logic [16:0] rr;
		logic [2:0] pp;
		r.pix    = idx;
		r.err    = err;
		r.x      = col;
		r.y      = row[15:0];
		r.in_img = (row < {1'b0, h});
		r.col    = col;
		r.row    = row;
		r.pass   = pass;
		nc = {1'b0, col} + 17'd1;
		rr = row + 17'(ROW_STEP[pass[1:0]]);
		pp = pass;
		if (r.in_img) begin
			if (nc < {1'b0, w} && !nc[16]) begin
				r.col = nc[15:0];
			end else begin
				r.col = '0;
				if (!il) begin
					r.row = row + 17'd1;
				end else begin
					for (int i = 0; i < 4; i++) begin
						if (rr >= {1'b0, h} && pp < 3'd4) begin
							pp = pp + 3'd1;
							if (pp < 3'd4) rr = 17'(ROW_STEP[pp[1:0]] >> 1);
						end
					end
					r.row  = rr;
					r.pass = pp;
				end
			end
		end
		return r;
	endfunction

	assign m_eff    = (min_q < 4'd2) ? 4'd2 : ((min_q > 4'd8) ? 4'd8 : min_q);
	assign clear_c  = CNT_BITS'(1) << m_eff;
	assign mask     = (20'd1 << cw_q) - 20'd1;
	assign code     = CODE_BITS'(bb_q & mask);
	assign take     = (state_q == S_IDLE) && q_valid && !ov_q;
	assign is_adv   = take && (q_item.kind == K_ADV);
	assign has_code = ({1'b0, bc_q} >= {2'b0, cw_q});
	assign is_clr   = ({1'b0, code} == clear_c);
	assign is_end   = ({1'b0, code} == clear_c + CNT_BITS'(1));
	assign p_ge     = ({1'b0, p_q} >= clear_c);
	assign p_ok     = ({1'b0, p_q} >= base_q) && ({1'b0, p_q} < next_q)
	                  && (sc_q < CNT_BITS'(STK_DEPTH - 1));
	assign sc_m1    = sc_q - CNT_BITS'(1);
	assign q_pop    = take;

	assign pl_a = do_place((code < CODE_BITS'(clear_c)) ? code[7:0] : 8'd0,
		!(code < CODE_BITS'(clear_c)), col_q, row_q, pass_q, w_q, h_q, il_q);
	assign pl_b = do_place((state_q == S_POP) ? stk_rd : p_q[7:0],
		(state_q == S_POP) ? 1'b0 : err_q, col_q, row_q, pass_q, w_q, h_q, il_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (is_adv) begin
					if (sc_q != '0) state_d = S_POP;
					else if (has_code && !is_clr && !is_end && !ac_q) state_d = S_WALK;
				end
			end
			S_POP:  state_d = S_IDLE;
			S_WALK: state_d = (p_ge && p_ok) ? S_WAIT : S_FIN;
			S_WAIT: state_d = S_WALK;
			S_FIN:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		sc_d = sc_q; next_d = next_q; base_d = base_q; bb_d = bb_q; bc_d = bc_q;
		sb_d = sb_q; cw_d = cw_q; prev_d = prev_q; p_d = p_q; code_d = code_q;
		fc_d = fc_q; ac_d = ac_q; fin_d = fin_q; err_d = err_q;
		col_d = col_q; row_d = row_q; pass_d = pass_q;
		out_load = 1'b0; ost_d = ST_PIXEL; opl_d = '0;
		tbl_we = 1'b0; tbl_wa = next_q[CODE_BITS-1:0]; tbl_wd = {prev_q, p_q[7:0]};
		stk_we = 1'b0; stk_wa = sc_q; stk_wd = tbl_rd[7:0];
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					case (q_item.kind)
						K_START: begin
							out_load = 1'b1; ost_d = ST_STARTED;
							cw_d = m_eff + 4'd1; next_d = clear_c + CNT_BITS'(2);
							base_d = clear_c + CNT_BITS'(2);
							sc_d = '0; bb_d = '0; bc_d = '0; sb_d = '0; prev_d = '0;
							fc_d = '0; ac_d = 1'b1; fin_d = 1'b0;
							col_d = '0; row_d = '0; pass_d = '0;
						end
						K_FEED: begin
							out_load = 1'b1;
							if (fin_q) begin
								ost_d = ST_REFUSE;
							end else if (sb_q == '0) begin
								if (q_item.data == '0) begin
									fin_d = 1'b1; ost_d = ST_END;
								end else begin
									sb_d = q_item.data; ost_d = ST_ACCEPT;
								end
							end else if (bc_q > 5'd12) begin
								ost_d = ST_REFUSE;
							end else begin
								bb_d = bb_q | (20'(q_item.data) << bc_q);
								bc_d = bc_q + 5'd8;
								sb_d = sb_q - 8'd1;
								ost_d = ST_ACCEPT;
							end
						end
						K_ADV: begin
							if (sc_q != '0) begin
							end else if (has_code) begin
								bb_d = bb_q >> cw_q;
								bc_d = bc_q - {1'b0, cw_q};
								if (is_clr) begin
									out_load = 1'b1; ost_d = ST_CLEAR;
									cw_d = m_eff + 4'd1; next_d = clear_c + CNT_BITS'(2);
									base_d = clear_c + CNT_BITS'(2); ac_d = 1'b1;
								end else if (is_end) begin
									out_load = 1'b1; ost_d = ST_END;
									fin_d = 1'b1; bb_d = '0; bc_d = '0;
								end else if (ac_q) begin
									ac_d = 1'b0; prev_d = code; fc_d = pl_a.pix;
									out_load = 1'b1; ost_d = ST_PIXEL; opl_d = pl_a;
									col_d = pl_a.col; row_d = pl_a.row; pass_d = pl_a.pass;
								end else begin
									code_d = code; err_d = 1'b0;
									if ({1'b0, code} >= next_q) begin
										stk_we = 1'b1; stk_wa = '0; stk_wd = fc_q;
										sc_d = CNT_BITS'(1); p_d = prev_q;
									end else begin
										sc_d = '0; p_d = code;
									end
								end
							end else begin
								out_load = 1'b1; ost_d = fin_q ? ST_END : ST_NEED;
							end
						end
						default: begin
							out_load = 1'b1; ost_d = ST_REFUSE;
						end
					endcase
				end
			end
			S_POP: begin
				sc_d = sc_m1;
				out_load = 1'b1; ost_d = ST_PIXEL; opl_d = pl_b;
				col_d = pl_b.col; row_d = pl_b.row; pass_d = pl_b.pass;
			end
			S_WALK: begin
				if (p_ge && !p_ok) begin
					err_d = 1'b1; p_d = '0;
				end
			end
			S_WAIT: begin
				stk_we = 1'b1;
				sc_d = sc_q + CNT_BITS'(1);
				p_d = tbl_rd[19:8];
			end
			S_FIN: begin
				fc_d = p_q[7:0];
				if (next_q < CNT_BITS'(TBL_DEPTH)) begin
					tbl_we = 1'b1;
					next_d = next_q + CNT_BITS'(1);
					if ((next_q + CNT_BITS'(1)) > ((CNT_BITS'(1) << cw_q) - CNT_BITS'(1))
						&& cw_q < 4'(CODE_BITS)) cw_d = cw_q + 4'd1;
				end
				prev_d = code_q;
				out_load = 1'b1; ost_d = ST_PIXEL; opl_d = pl_b;
				col_d = pl_b.col; row_d = pl_b.row; pass_d = pl_b.pass;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
		tbl_rd <= tbl_mem[p_q];
		if (stk_we) stk_mem[stk_wa[CODE_BITS-1:0]] <= stk_wd;
		stk_rd <= stk_mem[sc_m1[CODE_BITS-1:0]];
		if (out_load) begin
			ost_q <= ost_d;
			opl_q <= opl_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 4'd8; w_q <= 16'd1; h_q <= 16'd1; il_q <= 1'b0;
			state_q <= S_IDLE; ov_q <= 1'b0;
			sc_q <= '0; next_q <= CNT_BITS'(258); base_q <= CNT_BITS'(258);
			bb_q <= '0; bc_q <= '0; sb_q <= '0; cw_q <= 4'd9;
			prev_q <= '0; p_q <= '0; code_q <= '0; fc_q <= '0;
			ac_q <= 1'b1; fin_q <= 1'b0; err_q <= 1'b0;
			col_q <= '0; row_q <= '0; pass_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_MIN:    min_q <= cfg_data[3:0];
					CFG_WIDTH:  w_q   <= cfg_data;
					CFG_HEIGHT: h_q   <= cfg_data;
					CFG_ILACE:  il_q  <= cfg_data[0];
					default:    il_q  <= il_q;
				endcase
			end
			state_q <= state_d;
			if (out_load) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
			sc_q <= sc_d; next_q <= next_d; base_q <= base_d;
			bb_q <= bb_d; bc_q <= bc_d; sb_q <= sb_d; cw_q <= cw_d;
			prev_q <= prev_d; p_q <= p_d; code_q <= code_d; fc_q <= fc_d;
			ac_q <= ac_d; fin_q <= fin_d; err_q <= err_d;
			col_q <= col_d; row_q <= row_d; pass_q <= pass_d;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = ost_q;
	assign m_tdata  = {6'b0, opl_q.err, opl_q.in_img, opl_q.y, opl_q.x, opl_q.pix};

endmodule

### rtl/gif_lzw_pixel_decoder.sv
// GIF LZW pixel decoder top level: input queue and decode engine.
// Start, feed and plain answers are registered straight from idle; a stacked
// pixel passes through S_POP; a new code walks its string via S_WALK and S_WAIT
// (one table read per link), then ends in S_FIN. One item is taken at a time:
// the next is taken only once the output has been accepted.
// Reset: asynchronous, active low; configuration and decoder state to defaults.
// Table validity follows a fill range, so no clearing pass is needed.
module gif_lzw_pixel_decoder
	import gld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [1:0]  s_tuser,   // opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // pixel_index, pos_x, pos_y, inside_image, table_error
	output logic [2:0]  m_tuser,   // status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic    q_valid;
	logic    q_pop;
	q_item_t q_item;

	assign cfg_ready = 1'b1;

	gld_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	gld_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### test/tb_gif_lzw_pixel_decoder.sv
// Self-checking testbench for the GIF LZW pixel decoder: encoded streams in, checked pixels out.
module tb_gif_lzw_pixel_decoder;
	import gld_pkg::*;

	typedef struct {
		logic [2:0]  st;
		logic [47:0] d;
	} pixel_result_t;

	class pixel_scoreboard;
		logic [3:0]  min_cs = 4'd8;
		logic [15:0] img_w = 16'd1;
		logic [15:0] img_h = 16'd1;
		logic        ilace = 1'b0;
		logic [11:0] prefix_tbl [TBL_DEPTH];
		logic [7:0]  suffix_tbl [TBL_DEPTH];
		bit          entry_ok [TBL_DEPTH];
		logic [7:0]  chars [STK_DEPTH];
		int unsigned stk_n, bbuf, bcnt, sub_left, cw, ncode, prev, fch;
		int unsigned aclr, fin, col, row, pass_no;
		pixel_result_t pending [$];
		int fails;

		function new();
			start_image();
		endfunction

		function int unsigned eff_min();
			if (min_cs < 2) return 2;
			if (min_cs > 8) return 8;
			return min_cs;
		endfunction

		function void clear_table();
			foreach (entry_ok[i]) entry_ok[i] = 0;
			cw = eff_min() + 1;
			ncode = (1 << eff_min()) + 2;
		endfunction

		function void start_image();
			clear_table();
			stk_n = 0; bbuf = 0; bcnt = 0; sub_left = 0;
			prev = 0; fch = 0; aclr = 1; fin = 0;
			col = 0; row = 0; pass_no = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_MIN:    min_cs = val[3:0];
				CFG_WIDTH:  img_w = val;
				CFG_HEIGHT: img_h = val;
				CFG_ILACE:  ilace = val[0];
			endcase
		endfunction

		function logic [2:0] push_status(logic [2:0] st);
			pixel_result_t r;
			r.st = st;
			r.d = '0;
			pending.push_back(r);
			return st;
		endfunction

		function logic [2:0] place(int unsigned idx, bit err);
			pixel_result_t r;
			bit in_img;
			int unsigned nc;
			in_img = row < img_h;
			r.st = ST_PIXEL;
			r.d = {6'd0, err, in_img, row[15:0], col[15:0], idx[7:0]};
			pending.push_back(r);
			if (in_img) begin
				nc = col + 1;
				if (nc < img_w && nc <= 16'hFFFF) begin
					col = nc;
				end else begin
					col = 0;
					if (!ilace) begin
						row++;
					end else begin
						row += ROW_STEP[pass_no & 3];
						while (row >= img_h && pass_no < 4) begin
							pass_no++;
							if (pass_no < 4) row = ROW_STEP[pass_no] >> 1;
						end
					end
				end
			end
			return ST_PIXEL;
		endfunction

		function logic [2:0] take_code();
			int unsigned clr, code, p;
			bit err;
			clr = 1 << eff_min();
			code = bbuf & ((1 << cw) - 1);
			err = 0;
			bbuf >>= cw;
			bcnt -= cw;
			if (code == clr) begin
				clear_table();
				aclr = 1;
				return push_status(ST_CLEAR);
			end
			if (code == clr + 1) begin
				fin = 1; bbuf = 0; bcnt = 0;
				return push_status(ST_END);
			end
			if (aclr) begin
				aclr = 0;
				prev = code;
				if (code < clr) begin
					fch = code;
					return place(code, 0);
				end
				fch = 0;
				return place(0, 1);
			end
			stk_n = 0;
			if (code >= ncode) begin
				chars[stk_n++] = fch[7:0];
				p = prev;
			end else begin
				p = code;
			end
			while (p >= clr) begin
				p &= TBL_DEPTH - 1;
				if (!entry_ok[p] || stk_n >= STK_DEPTH - 1) begin
					err = 1; p = 0;
					break;
				end
				chars[stk_n++] = suffix_tbl[p];
				p = prefix_tbl[p];
			end
			chars[stk_n++] = p[7:0];
			fch = p & 8'hFF;
			if (ncode < TBL_DEPTH) begin
				prefix_tbl[ncode] = prev[11:0];
				suffix_tbl[ncode] = fch[7:0];
				entry_ok[ncode] = 1;
				ncode++;
				if (ncode > (1 << cw) - 1 && cw < CODE_BITS) cw++;
			end
			prev = code & (TBL_DEPTH - 1);
			stk_n--;
			return place(chars[stk_n], err);
		endfunction

		function logic [2:0] note_input(logic [1:0] op, logic [7:0] b);
			case (op)
				OP_START: begin
					start_image();
					return push_status(ST_STARTED);
				end
				OP_FEED: begin
					if (fin) return push_status(ST_REFUSE);
					if (sub_left == 0) begin
						if (b == 0) begin
							fin = 1;
							return push_status(ST_END);
						end
						sub_left = b;
						return push_status(ST_ACCEPT);
					end
					if (bcnt > 12) return push_status(ST_REFUSE);
					bbuf = (bbuf | (int'(b) << bcnt)) & 20'hFFFFF;
					bcnt += 8;
					sub_left--;
					return push_status(ST_ACCEPT);
				end
				OP_ADV: begin
					if (stk_n > 0) begin
						stk_n--;
						return place(chars[stk_n], 0);
					end
					if (bcnt >= cw) return take_code();
					return push_status(fin ? ST_END : ST_NEED);
				end
				default: return push_status(ST_REFUSE);
			endcase
		endfunction

		function void check_result(logic [2:0] st, logic [47:0] d);
			pixel_result_t e;
			if (pending.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected result status=%0d data=%h", st, d);
				return;
			end
			e = pending.pop_front();
			if (st !== e.st || d !== e.d) begin
				fails++;
				if (fails <= 10)
					$display("mismatch: expected status=%0d data=%h, got status=%0d data=%h",
						e.st, e.d, st, d);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pixel_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;

	gif_lzw_pixel_decoder uut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#40000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send(input logic [1:0] op, input logic [7:0] b, output logic [2:0] st);
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		st = sb.note_input(op, b);
		items_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Encode codes LSB first at the decoder's running width, then split into sub-blocks.
	task automatic run_image(input int ncodes, input int forced [$]);
		bit          bq [$];
		logic [7:0]  bytes [$];
		logic [7:0]  b;
		logic [2:0]  st;
		int unsigned m, clr, w, n, code, hi, len, guard;
		bit          aclr;
		bit          directed;
		directed = forced.size() != 0;
		m = sb.eff_min();
		clr = 1 << m;
		w = m + 1; n = clr + 2; aclr = 1;
		if (directed) ncodes = forced.size();
		for (int i = 0; i < ncodes; i++) begin
			hi = (n < (1 << w) - 1) ? n : (1 << w) - 1;
			if (directed) begin
				code = forced.pop_front();
			end else if ($urandom_range(99) < 3) begin
				code = clr;
			end else if (aclr) begin
				code = ($urandom_range(99) < 3) ? $urandom_range((1 << w) - 1, clr + 2)
					: $urandom_range(clr - 1, 0);
			end else if ($urandom_range(99) < 4 && hi < (1 << w) - 1) begin
				code = $urandom_range((1 << w) - 1, hi + 1);
			end else begin
				code = $urandom_range(hi, 0);
				if (code == clr + 1) code = clr + 2 <= hi ? clr + 2 : 0;
			end
			for (int k = 0; k < w; k++) bq.push_back(code[k]);
			if (code == clr + 1) break;
			if (code == clr) begin
				w = m + 1; n = clr + 2; aclr = 1;
			end else if (aclr) begin
				aclr = 0;
			end else if (n < TBL_DEPTH) begin
				n++;
				if (n > (1 << w) - 1 && w < CODE_BITS) w++;
			end
		end
		if (!directed && $urandom_range(99) < 70)
			for (int k = 0; k < w; k++) bq.push_back(((clr + 1) >> k) & 1);
		while (bq.size() % 8 != 0) bq.push_back(0);
		while (bq.size() != 0) begin
			len = bq.size() / 8;
			len = $urandom_range(len < 20 ? len : 20, 1);
			bytes.push_back(len[7:0]);
			repeat (len) begin
				for (int k = 0; k < 8; k++) b[k] = bq.pop_front();
				bytes.push_back(b);
			end
		end
		if (directed || $urandom_range(99) < 80) bytes.push_back(8'd0);
		while (bytes.size() != 0) begin
			if ($urandom_range(999) < 15) begin
				send($urandom_range(3, 1), $urandom_range(255), st);
			end else if ((sb.sub_left == 0 || sb.bcnt <= 12) && $urandom_range(99) < 55) begin
				send(OP_FEED, bytes.pop_front(), st);
			end else begin
				send(OP_ADV, 8'd0, st);
			end
		end
		guard = 0;
		do begin
			send(OP_ADV, 8'd0, st);
			guard++;
		end while (st != ST_END && st != ST_NEED && guard < 5000);
	endtask

	initial begin
		logic [2:0] st;
		int empty [$];
		int hi_w, hi_h;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(CFG_MIN, 16'd2);
		write_reg(CFG_WIDTH, 16'd3);
		write_reg(CFG_HEIGHT, 16'd2);
		write_reg(CFG_ILACE, 16'd0);
		send(OP_START, 8'd0, st);
		send(OP_ADV, 8'd0, st);
		run_image(0, '{4, 6, 1, 2, 3, 4, 0, 1, 7, 15, 5});
		send(OP_FEED, 8'hFF, st);
		send(2'd3, 8'hA5, st);
		send(OP_ADV, 8'd0, st);
		drain();

		for (int img = 0; items_sent < 1600; img++) begin
			case (img % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				3: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			drain();
			case ($urandom_range(9))
				0: write_reg(CFG_MIN, $urandom_range(15));
				1: write_reg(CFG_MIN, 16'd8);
				2: write_reg(CFG_MIN, 16'd2);
				default: write_reg(CFG_MIN, $urandom_range(8, 2));
			endcase
			hi_w = $urandom_range(9);
			hi_h = $urandom_range(9);
			write_reg(CFG_WIDTH, hi_w == 0 ? 16'hFFFF : hi_w == 1 ? 16'd1 : $urandom_range(20, 1));
			write_reg(CFG_HEIGHT, hi_h == 0 ? 16'hFFFF : hi_h == 1 ? 16'd0 : $urandom_range(12, 1));
			write_reg(CFG_ILACE, $urandom_range(1));
			send(OP_START, $urandom_range(255), st);
			run_image($urandom_range(120, 10), empty);
		end
		drain();
		if (sb.fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
